/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  `ASSERT_CLK(label, (expr), msg)

`endif

/* src/flrl_pkg.sv */
`default_nettype none
package flrl_pkg;

  localparam logic [7:0]  KIND_WRITE     = 8'hC9;
  localparam logic [7:0]  KIND_SKIP      = 8'hED;
  localparam logic [3:0]  HDR_LEN        = 4'd10;
  localparam logic [3:0]  SKIP_LONG_LEN  = 4'd10;
  localparam logic [3:0]  SKIP_SHORT_LEN = 4'd2;
  localparam logic [3:0]  HB_LEN_HI      = 4'd1;
  localparam logic [3:0]  HB_LEN_MID     = 4'd2;
  localparam logic [3:0]  HB_LEN_LO      = 4'd3;
  localparam logic [3:0]  HB_ADDR_FIRST  = 4'd6;
  localparam logic [23:0] LEN_OVERHEAD   = 24'd6;
  localparam int          QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WHEAD,
    PH_SKIP,
    PH_DATA
  } phase_t;

  // One data byte of a write record, as the parser hands it to the packer.
  typedef struct packed {
    logic [7:0]  data;
    logic        rec_end;
    logic        img_last;
    logic        first;
    logic [31:0] addr;
  } tok_t;

endpackage
`default_nettype wire

/* src/flrl_front.sv */
`default_nettype none
module flrl_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_image_last,
  output logic               push,
  output flrl_pkg::tok_t     push_tok
);
  import flrl_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        skip_long_r, skip_long_nxt;
  logic        first_r, first_nxt;

  logic        acc;
  logic [3:0]  hc_inc;
  logic [23:0] len_full;
  logic [3:0]  skip_lim;
  logic        data_end;

  assign acc      = in_valid && !in_stall;
  assign hc_inc   = hc_r + 4'd1;
  assign len_full = {len_hi_r, rem_r[7:0], in_byte};
  assign skip_lim = skip_long_r ? SKIP_LONG_LEN : SKIP_SHORT_LEN;
  assign data_end = (rem_r == 24'd1);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        PH_IDLE:  phase_nxt = (in_byte == KIND_WRITE) ? PH_WHEAD : PH_SKIP;
        PH_WHEAD: begin
          if (hc_inc == HDR_LEN) begin
            phase_nxt = (rem_r == 24'd0) ? PH_IDLE : PH_DATA;
          end
        end
        PH_SKIP:  begin
          if (hc_inc >= skip_lim) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_DATA:  begin
          if (data_end) begin
            phase_nxt = PH_IDLE;
          end
        end
        default:  phase_nxt = PH_IDLE;
      endcase
      // The end of the image always puts the parser back to its start.
      if (in_image_last) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  // Header fields, counters and the data byte handed to the queue.
  always_comb begin
    hc_nxt        = hc_r;
    len_hi_nxt    = len_hi_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    skip_long_nxt = skip_long_r;
    first_nxt     = first_r;
    push          = 1'b0;
    push_tok      = '{data: in_byte, rec_end: data_end, img_last: in_image_last,
                      first: first_r, addr: addr_r};
    if (acc) begin
      unique case (phase_r)
        PH_IDLE: begin
          hc_nxt        = 4'd1;
          skip_long_nxt = (in_byte == KIND_SKIP);
        end
        PH_WHEAD: begin
          if (hc_r == HB_LEN_HI) begin
            len_hi_nxt = in_byte;
          end else if (hc_r == HB_LEN_MID) begin
            rem_nxt = {16'd0, in_byte};
          end else if (hc_r == HB_LEN_LO) begin
            rem_nxt = (len_full >= LEN_OVERHEAD) ? (len_full - LEN_OVERHEAD) : 24'd0;
          end else if (hc_r >= HB_ADDR_FIRST) begin
            addr_nxt = {addr_r[23:0], in_byte};
          end
          hc_nxt = hc_inc;
          if (hc_inc == HDR_LEN) begin
            first_nxt = 1'b1;
          end
        end
        PH_SKIP: hc_nxt = hc_inc;
        PH_DATA: begin
          push      = 1'b1;
          rem_nxt   = rem_r - 24'd1;
          first_nxt = 1'b0;
        end
        default: hc_nxt = hc_r;
      endcase
      if (in_image_last) begin
        hc_nxt     = 4'd0;
        len_hi_nxt = 8'd0;
        rem_nxt    = 24'd0;
        addr_nxt   = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hc_r        <= 4'd0;
      len_hi_r    <= 8'd0;
      rem_r       <= 24'd0;
      addr_r      <= 32'd0;
      skip_long_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      hc_r        <= hc_nxt;
      len_hi_r    <= len_hi_nxt;
      rem_r       <= rem_nxt;
      addr_r      <= addr_nxt;
      skip_long_r <= skip_long_nxt;
      first_r     <= first_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/flrl_queue.sv */
`default_nettype none
module flrl_queue #(
  parameter int DEPTH = flrl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire flrl_pkg::tok_t push_tok,
  output logic               full,
  output logic               pop_valid,
  input  wire logic          pop,
  output flrl_pkg::tok_t     pop_tok
);
  import flrl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  tok_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign full      = (cnt_r == CNT_MAX);
  assign pop_valid = (cnt_r != '0);
  assign pop_tok   = slot_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/flrl_back.sv */
`default_nettype none
module flrl_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          tok_valid,
  input  wire flrl_pkg::tok_t tok,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [31:0]        out_word_address,
  output logic [31:0]        out_word_data,
  output logic               out_record_last,
  output logic               out_truncated
);
  import flrl_pkg::*;

  logic [1:0]  lane_r, lane_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] oaddr_r, oaddr_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic        olast_r, olast_nxt;
  logic        otrunc_r, otrunc_nxt;

  logic [31:0] base_addr;
  logic [31:0] word_base;
  logic [31:0] word_cur;
  logic        emit;

  // Bytes land in their final lane, so a short word is already zero padded.
  assign base_addr = tok.first ? tok.addr : addr_r;
  assign word_base = (lane_r == 2'd0) ? 32'd0 : word_r;
  assign word_cur  = word_base | ({24'd0, tok.data} << {~lane_r, 3'b000});
  assign emit      = (lane_r == 2'd3) || tok.rec_end || tok.img_last;
  assign pop       = tok_valid && (!ov_r || !out_stall);

  always_comb begin
    lane_nxt   = lane_r;
    word_nxt   = word_r;
    addr_nxt   = addr_r;
    ov_nxt     = ov_r && out_stall;
    oaddr_nxt  = oaddr_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    otrunc_nxt = otrunc_r;
    if (pop) begin
      if (emit) begin
        ov_nxt     = 1'b1;
        oaddr_nxt  = base_addr;
        odata_nxt  = word_cur;
        olast_nxt  = tok.rec_end || tok.img_last;
        otrunc_nxt = tok.img_last && !tok.rec_end;
        addr_nxt   = base_addr + 32'd1;
        lane_nxt   = 2'd0;
      end else begin
        word_nxt = word_cur;
        addr_nxt = base_addr;
        lane_nxt = lane_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    addr_r   <= addr_nxt;
    oaddr_r  <= oaddr_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
    otrunc_r <= otrunc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r <= 2'd0;
      ov_r   <= 1'b0;
    end else begin
      lane_r <= lane_nxt;
      ov_r   <= ov_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_word_address = oaddr_r;
  assign out_word_data    = odata_r;
  assign out_record_last  = olast_r;
  assign out_truncated    = otrunc_r;

endmodule
`default_nettype wire

/* src/firmware_record_ram_loader_top.sv */
// Channel  Ports                                               Accepted when
// in       in_valid in_stall in_byte in_image_last            in_valid && !in_stall
// out      out_valid out_stall out_word_address out_word_data  out_valid && !out_stall
//          out_record_last out_truncated
//
// One image byte is taken per cycle while the byte queue is not full; the byte that
// completes a data word passes through the byte queue and then the output register.
// The parser is held back only when the byte queue (QUEUE_DEPTH entries) is full.
// The packer drains one queued byte per cycle whenever the output register is free.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to the
// start of a record.
`default_nettype none
module firmware_record_ram_loader_top #(
  parameter int QUEUE_DEPTH = flrl_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_image_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_word_address,
  output logic [31:0]      out_word_data,
  output logic             out_record_last,
  output logic             out_truncated
);
  import flrl_pkg::*;

  logic push;
  tok_t push_tok;
  logic q_full;
  logic q_valid;
  logic q_pop;
  tok_t q_tok;

  assign in_stall = q_full;

  flrl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .in_image_last (in_image_last),
    .push          (push),
    .push_tok      (push_tok)
  );

  flrl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (push_tok),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_tok   (q_tok)
  );

  flrl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .tok_valid        (q_valid),
    .tok              (q_tok),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_address (out_word_address),
    .out_word_data    (out_word_data),
    .out_record_last  (out_record_last),
    .out_truncated    (out_truncated)
  );

endmodule
`default_nettype wire

/* src/flrl_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module flrl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_byte,
  input wire logic        in_image_last,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_word_address,
  input wire logic [31:0] out_word_data,
  input wire logic        out_record_last,
  input wire logic        out_truncated
);

  logic        in_wait;
  logic [8:0]  in_word;
  logic        out_wait;
  logic [65:0] out_word;
  logic        trunc_ok;
  logic        out_mid;
  logic [31:0] addr_next_r;
  logic        addr_in_step;

  assign in_wait      = in_valid && in_stall;
  assign in_word      = {in_byte, in_image_last};
  assign out_wait     = out_valid && out_stall;
  assign out_word     = {out_word_address, out_word_data, out_record_last, out_truncated};
  assign trunc_ok     = !out_valid || !out_truncated || out_record_last;
  assign out_mid      = out_valid && !out_stall && !out_record_last;
  assign addr_in_step = (out_word_address == addr_next_r);

  always_ff @(posedge clk) begin
    addr_next_r <= out_word_address + 32'd1;
  end

  // A stalled input word must be offered again unchanged.
  `ASSERT_CLK(a_in_hold, in_wait |=> in_valid && $stable(in_word), "stalled input word changed")

  // A stalled word must be offered again unchanged.
  `ASSERT_CLK(a_out_hold, out_wait |=> out_valid && $stable(out_word), "stalled output word changed")

  // A word cut short by the end of the image also closes its record.
  `ASSERT_ALWAYS(a_trunc_is_last, trunc_ok, "truncated word without record_last")

  // Inside a record, words that follow back to back go to consecutive addresses.
  `ASSERT_CLK(a_addr_step, out_mid ##1 out_valid |-> addr_in_step, "address did not step")

endmodule

bind firmware_record_ram_loader_top flrl_checker u_chk (.*);
`default_nettype wire
